>>> hdl/rte_pkg.sv
// rte_pkg: shared types and constants for the trap entry block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rte_pkg;
   typedef struct packed {
      logic        interrupt_flag;
      logic [5:0]  cause_code;
      logic [63:0] fault_pc;
      logic [63:0] fetch_address;
      logic [2:0]  fetch_offset_bytes;
      logic [63:0] data_address;
      logic [31:0] instruction_word;
   } req_type;

   typedef struct packed {
      logic [63:0] handler_pc;
      logic [1:0]  target_level;
      logic [63:0] cause_value;
      logic [63:0] trap_value;
      logic        guest_address_flag;
      logic [1:0]  previous_privilege;
   } rsp_type;

   typedef enum logic [2:0] {
      CSR_MEDELEG = 3'd0,
      CSR_MIDELEG = 3'd1,
      CSR_HEDELEG = 3'd2,
      CSR_HIDELEG = 3'd3,
      CSR_MTVEC   = 3'd4,
      CSR_STVEC   = 3'd5,
      CSR_VSTVEC  = 3'd6,
      CSR_HYP     = 3'd7
   } csr_index_type;

   localparam logic [1:0] LVL_M  = 2'd0;
   localparam logic [1:0] LVL_HS = 2'd1;
   localparam logic [1:0] LVL_VS = 2'd2;
   localparam logic [1:0] PRIV_M = 2'd3;
   localparam logic [1:0] PRIV_S = 2'd1;

   // classified trap, handed from front to back
   typedef struct packed {
      logic        intr;
      logic [5:0]  code;
      logic [63:0] fault_pc;
      logic [63:0] tval;
      logic        addr_fault;
      logic [31:0] insn;
   } trap_type;

   function automatic logic is_fetch_fault(input logic [5:0] c);
      return c == 6'd0 || c == 6'd1 || c == 6'd12 || c == 6'd20;
   endfunction

   function automatic logic is_data_fault(input logic [5:0] c);
      return c == 6'd4 || c == 6'd5 || c == 6'd6 || c == 6'd7 || c == 6'd13 ||
             c == 6'd15 || c == 6'd21 || c == 6'd23;
   endfunction
endpackage
`default_nettype wire

>>> hdl/rte_front.sv
// rte_front: accepts trap items, works out the trap value and fault class
// depends on rte_pkg
`timescale 1ns / 1ps
`default_nettype none
module rte_front (
   input  wire  rte_pkg::req_type  req_item,
   output rte_pkg::trap_type       trap_item
);
   import rte_pkg::*;
   logic [63:0] tv;
   always_comb begin
      tv = '0;
      if (!req_item.interrupt_flag) begin
         if (is_fetch_fault(req_item.cause_code))
            tv = req_item.fetch_address + {61'd0, req_item.fetch_offset_bytes};
         else if (is_data_fault(req_item.cause_code))
            tv = req_item.data_address;
         else if (req_item.cause_code == 6'd2 || req_item.cause_code == 6'd22)
            tv = {32'd0, req_item.instruction_word};
      end
      trap_item.intr       = req_item.interrupt_flag;
      trap_item.code       = req_item.cause_code;
      trap_item.fault_pc   = req_item.fault_pc;
      trap_item.tval       = tv;
      trap_item.addr_fault = !req_item.interrupt_flag &&
         (is_fetch_fault(req_item.cause_code) || is_data_fault(req_item.cause_code));
      trap_item.insn       = req_item.instruction_word;
   end
endmodule
`default_nettype wire

>>> hdl/rte_queue.sv
// rte_queue: two-entry queue between front and back
// depends on rte_pkg
`timescale 1ns / 1ps
`default_nettype none
module rte_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  wire  rte_pkg::trap_type in_item,
   output logic                    out_valid,
   input  wire                     out_ready,
   output rte_pkg::trap_type       out_item
);
   import rte_pkg::*;
   trap_type   mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_item  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule
`default_nettype wire

>>> hdl/rte_back.sv
// rte_back: applies delegation, updates architectural trap state, forms results
// depends on rte_pkg
`timescale 1ns / 1ps
`default_nettype none
module rte_back #(
   parameter int unsigned XLEN_BITS = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_valid,
   input  wire  [2:0]              csr_index,
   input  wire  [63:0]             csr_data,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  wire  rte_pkg::trap_type in_item,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output rte_pkg::rsp_type        rsp_item
);
   import rte_pkg::*;
   localparam logic [63:0] XMask = (XLEN_BITS >= 64) ? '1 : ((64'd1 << XLEN_BITS) - 64'd1);
   localparam logic [63:0] IntBit = 64'd1 << (XLEN_BITS - 1);

   logic [63:0] medeleg_ff, mideleg_ff, hedeleg_ff, hideleg_ff;
   logic [63:0] mtvec_ff, stvec_ff, vstvec_ff;
   logic        hyp_ff;
   logic [1:0]  priv_ff, priv_in;
   logic        virt_ff, virt_in;
   logic [7:0]  mstat_ff, mstat_in;
   logic [3:0]  sstat_ff, sstat_in, vsstat_ff, vsstat_in, hstat_ff, hstat_in;
   logic [63:0] epc_ff [3];
   logic [63:0] cause_ff [3];
   logic [63:0] tval_ff [3];
   logic [63:0] htinst_ff, htinst_in, htval_ff;
   logic [5:0]  last_code_ff;
   logic        out_valid_ff;
   rsp_type     out_ff, out_in;

   logic        take, md, hd, gva;
   logic [1:0]  lvl;
   logic [63:0] cause, tvec, base;

   assign in_ready  = !out_valid_ff || rsp_ready;
   assign take      = in_valid && in_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      md = ({58'd0, in_item.code} < 64'(XLEN_BITS)) &&
           (in_item.intr ? mideleg_ff[in_item.code] : medeleg_ff[in_item.code]);
      hd = ({58'd0, in_item.code} < 64'(XLEN_BITS)) &&
           (in_item.intr ? hideleg_ff[in_item.code] : hedeleg_ff[in_item.code]);
      lvl = LVL_M;
      if (priv_ff != PRIV_M && md) lvl = (virt_ff && hd) ? LVL_VS : LVL_HS;
      cause = (in_item.intr ? ({58'd0, in_item.code} | IntBit) : {58'd0, in_item.code}) & XMask;
      gva = 1'b0;
      priv_in = (lvl == LVL_M) ? PRIV_M : PRIV_S;
      virt_in = lvl == LVL_VS;
      mstat_in = mstat_ff; sstat_in = sstat_ff; vsstat_in = vsstat_ff;
      hstat_in = hstat_ff; htinst_in = htinst_ff;
      case (lvl)
         LVL_VS: begin
            tvec = vstvec_ff;
            vsstat_in = {1'b0, priv_ff[0], vsstat_ff[0], 1'b0};
         end
         LVL_HS: begin
            tvec = stvec_ff;
            sstat_in = {1'b0, priv_ff[0], sstat_ff[0], 1'b0};
            if (hyp_ff) begin
               gva = virt_ff && in_item.addr_fault;
               hstat_in = {hstat_ff[3], gva, virt_ff ? priv_ff[0] : hstat_ff[1], virt_ff};
               htinst_in = {32'd0, in_item.insn};
            end
         end
         default: begin
            tvec = mtvec_ff;
            mstat_in = {mstat_ff[7:4], priv_ff, mstat_ff[0], 1'b0};
            if (hyp_ff) begin
               gva = virt_ff && in_item.addr_fault;
               mstat_in[5:4] = {gva, virt_ff};
            end
         end
      endcase
      tvec = tvec & XMask;
      base = {tvec[63:2], 2'b00};
      out_in.target_level       = lvl;
      out_in.cause_value        = cause;
      out_in.trap_value         = in_item.tval & XMask;
      out_in.guest_address_flag = gva;
      out_in.previous_privilege = priv_ff;
      case (tvec[1:0])
         2'd0: out_in.handler_pc = base;
         2'd1: out_in.handler_pc = (base + (in_item.intr ? {56'd0, in_item.code, 2'b00}
                                             : 64'd0)) & XMask;
         default: out_in.handler_pc = XMask;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         medeleg_ff <= '0; mideleg_ff <= '0; hedeleg_ff <= '0; hideleg_ff <= '0;
         mtvec_ff <= '0; stvec_ff <= '0; vstvec_ff <= '0; hyp_ff <= 1'b0;
         priv_ff <= PRIV_M; virt_ff <= 1'b0; mstat_ff <= '0; sstat_ff <= '0;
         vsstat_ff <= '0; hstat_ff <= '0; htinst_ff <= '0; htval_ff <= '0;
         last_code_ff <= '0; out_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            epc_ff[i] <= '0; cause_ff[i] <= '0; tval_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_MEDELEG: medeleg_ff <= csr_data;
               CSR_MIDELEG: mideleg_ff <= csr_data;
               CSR_HEDELEG: hedeleg_ff <= csr_data;
               CSR_HIDELEG: hideleg_ff <= csr_data;
               CSR_MTVEC:   mtvec_ff   <= csr_data;
               CSR_STVEC:   stvec_ff   <= csr_data;
               CSR_VSTVEC:  vstvec_ff  <= csr_data;
               default:     hyp_ff     <= csr_data[0];
            endcase
         end
         if (in_ready) out_valid_ff <= in_valid;
         if (take) begin
            priv_ff <= priv_in; virt_ff <= virt_in; mstat_ff <= mstat_in;
            sstat_ff <= sstat_in; vsstat_ff <= vsstat_in; hstat_ff <= hstat_in;
            htinst_ff <= htinst_in; last_code_ff <= in_item.code;
            if (lvl == LVL_HS && hyp_ff) htval_ff <= '0;
            epc_ff[lvl]   <= in_item.fault_pc & XMask;
            cause_ff[lvl] <= cause;
            tval_ff[lvl]  <= in_item.tval & XMask;
         end
      end
      if (take) out_ff <= out_in;
   end

   // a trap taken from machine mode always lands in machine mode
   assert property (@(posedge clock) disable iff (reset)
      take && priv_ff == PRIV_M |-> lvl == LVL_M) else $error("m-mode trap delegated");
   // only vs traps leave the hart virtualised
   assert property (@(posedge clock) disable iff (reset)
      take |=> virt_ff == (out_ff.target_level == LVL_VS)) else $error("virt mismatch");
   // the privilege after a trap is machine or supervisor
   assert property (@(posedge clock) disable iff (reset)
      take |=> (priv_ff == PRIV_M) == (out_ff.target_level == LVL_M))
      else $error("privilege mismatch");
endmodule
`default_nettype wire

>>> hdl/riscv_trap_entry.sv
// riscv_trap_entry: top level of the trap entry block
// depends on rte_pkg, rte_front, rte_queue, rte_back
`timescale 1ns / 1ps
`default_nettype none
// trap entry with hypervisor delegation. one item per cycle is accepted while
// the queue is not full, and each item yields one result item: the front
// classifies the trap and works out tval, a two-entry queue decouples it
// from the back, which resolves m/hs/vs delegation against the current
// privilege, updates epc/cause/tval and the status bits, and registers the
// handler pc. the privilege update closes a loop in the back, which still
// sustains one item per cycle while rsp_ready is held high. configuration
// writes are always taken and must only be issued while the block is idle.
module riscv_trap_entry #(
   parameter int unsigned XLEN_BITS = 64
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire  rte_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output rte_pkg::rsp_type       rsp_data,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [2:0]             csr_index,
   input  wire  [63:0]            csr_data
);
   import rte_pkg::*;
   trap_type front_item, back_item;
   logic     back_valid, back_ready;

   assign csr_ready = 1'b1;

   // front: classification
   rte_front u_front (.req_item(req_data), .trap_item(front_item));

   // queue: lets front and back stall apart
   rte_queue u_queue (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_item(front_item),
      .out_valid(back_valid), .out_ready(back_ready), .out_item(back_item)
   );

   // back: delegation and state update
   rte_back #(.XLEN_BITS(XLEN_BITS)) u_back (
      .clock, .reset,
      .csr_valid, .csr_index, .csr_data,
      .in_valid(back_valid), .in_ready(back_ready), .in_item(back_item),
      .rsp_valid, .rsp_ready, .rsp_item(rsp_data)
   );
endmodule
`default_nettype wire
